[sv/dse_pkg.sv]
// ----------------------------------------------------------------------------
// dse_pkg
// Shared constants and types for the DLE/STX frame encoder.
// ----------------------------------------------------------------------------
package dse_pkg;

	localparam logic [7:0] SYM_DLE = 8'h10;
	localparam logic [7:0] SYM_STX = 8'h02;
	localparam logic [7:0] SYM_ETX = 8'h03;

	localparam int MAX_RUN = 7;
	localparam int CNT_W   = $clog2(MAX_RUN + 1);

	typedef logic [7:0]       byte_t;
	typedef logic [CNT_W-1:0] cnt_t;

	typedef struct packed {
		logic [MAX_RUN-1:0][7:0] seq;
		cnt_t                    count;
		byte_t                   check_next;
	} run_t;

endpackage

[sv/dse_expand.sv]
// ----------------------------------------------------------------------------
// dse_expand
// Expands one input word into its run of framed bytes and next check byte.
// ----------------------------------------------------------------------------
module dse_expand (
	input  dse_pkg::byte_t data_byte,
	input  logic           has_data,
	input  logic           start_of_frame,
	input  logic           end_of_frame,
	input  dse_pkg::byte_t check_acc,
	output dse_pkg::run_t  run
);
	import dse_pkg::*;

	always_comb begin
		cnt_t  k;
		byte_t chk;
		k   = '0;
		chk = check_acc;
		run = '0;
		if (start_of_frame) begin
			chk = '0;
			run.seq[k] = SYM_DLE;
			k = k + cnt_t'(1);
			run.seq[k] = SYM_STX;
			k = k + cnt_t'(1);
		end
		if (has_data) begin
			if (data_byte == SYM_DLE) begin
				run.seq[k] = SYM_DLE;
				k = k + cnt_t'(1);
			end
			run.seq[k] = data_byte;
			k = k + cnt_t'(1);
			chk = chk ^ data_byte;
		end
		if (end_of_frame) begin
			run.seq[k] = SYM_DLE;
			k = k + cnt_t'(1);
			run.seq[k] = SYM_ETX;
			k = k + cnt_t'(1);
			run.seq[k] = chk ^ SYM_ETX;
			k = k + cnt_t'(1);
			chk = '0;
		end
		run.count      = k;
		run.check_next = chk;
	end

endmodule

[sv/dle_stx_frame_encoder.sv]
// ----------------------------------------------------------------------------
// dle_stx_frame_encoder
// Byte-stuffing frame encoder with DLE STX / DLE ETX markers and XOR check.
// ----------------------------------------------------------------------------
// Each input word produces one output word per framed byte: none for an idle
// word, one for a plain payload byte, up to seven for a one-byte frame whose
// payload is DLE. The single output register sets the pace at one byte per
// cycle while the sink is ready; the next input word is taken in the same
// cycle that a run's last byte enters the output register, so no gaps occur.
module dle_stx_frame_encoder (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
	input  logic [1:0] s_axis_tuser,   // [0] has_data, [1] start_of_frame
	input  logic       s_axis_tlast,   // end_of_frame
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata,   // [7:0] out_byte
	output logic       m_axis_tlast    // run_last
);
	import dse_pkg::*;

	run_t  run;
	byte_t check_acc_q;
	logic [MAX_RUN-1:0][7:0] seq_s1;
	cnt_t  count_s1;
	cnt_t  idx_q;
	logic  busy_s1;
	logic  m_valid_q;
	byte_t m_data_q;
	logic  m_last_q;
	logic  out_adv;
	logic  last_idx;
	logic  move;
	logic  in_acc;

	dse_expand u_expand (
		.data_byte      (s_axis_tdata),
		.has_data       (s_axis_tuser[0]),
		.start_of_frame (s_axis_tuser[1]),
		.end_of_frame   (s_axis_tlast),
		.check_acc      (check_acc_q),
		.run            (run)
	);

	assign out_adv       = !m_valid_q || m_axis_tready;
	assign last_idx      = (idx_q == count_s1 - cnt_t'(1));
	assign move          = busy_s1 && out_adv;
	assign s_axis_tready = !busy_s1 || (out_adv && last_idx);
	assign in_acc        = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			check_acc_q <= '0;
			busy_s1     <= 1'b0;
			idx_q       <= '0;
			m_valid_q   <= 1'b0;
		end else begin
			if (in_acc) begin
				check_acc_q <= run.check_next;
			end
			if (in_acc && run.count != '0) begin
				busy_s1 <= 1'b1;
				idx_q   <= '0;
			end else if (move) begin
				idx_q <= idx_q + cnt_t'(1);
				if (last_idx) begin
					busy_s1 <= 1'b0;
				end
			end
			if (move) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			seq_s1   <= run.seq;
			count_s1 <= run.count;
		end
		if (move) begin
			m_data_q <= seq_s1[idx_q];
			m_last_q <= last_idx;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;
	assign m_axis_tlast  = m_last_q;

endmodule

[sv/dse_chk.sv]
// ----------------------------------------------------------------------------
// dse_chk
// Port-level checks for the DLE/STX frame encoder, bound to the top level.
// ----------------------------------------------------------------------------
module dse_chk (
	input logic       clk,
	input logic       arst_n,
	input logic       s_axis_tvalid,
	input logic       s_axis_tready,
	input logic [7:0] s_axis_tdata,
	input logic [1:0] s_axis_tuser,
	input logic       s_axis_tlast,
	input logic       m_axis_tvalid,
	input logic       m_axis_tready,
	input logic [7:0] m_axis_tdata,
	input logic       m_axis_tlast
);
	import dse_pkg::*;

	logic out_acc;
	logic pend_dle_q;
	logic in_acc;
	logic in_stuff_q;

	assign out_acc = m_axis_tvalid && m_axis_tready;
	assign in_acc  = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_dle_q <= 1'b0;
			in_stuff_q <= 1'b0;
		end else begin
			if (out_acc) begin
				pend_dle_q <= (m_axis_tdata == SYM_DLE) && !m_axis_tlast;
			end
			in_stuff_q <= in_acc && s_axis_tuser[0] && (s_axis_tdata == SYM_DLE) &&
				!s_axis_tuser[1] && !s_axis_tlast;
		end
	end

	// a DLE inside a run is always followed by DLE, STX or ETX
	a_dle_follow: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc && pend_dle_q |->
			(m_axis_tdata == SYM_DLE || m_axis_tdata == SYM_STX ||
			 m_axis_tdata == SYM_ETX))
		else $error("DLE followed by an unexpected byte");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
		else $error("output word changed while stalled");

	a_reset_idle: assert property (@(posedge clk)
		$past(!arst_n) |-> !m_axis_tvalid)
		else $error("output valid right after reset");

	// a stuffed DLE run has two bytes, so input stalls the next cycle
	a_stuff_stall: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && s_axis_tuser[0] && s_axis_tdata == SYM_DLE &&
			!s_axis_tuser[1] && !s_axis_tlast |=> !s_axis_tready)
		else $error("input taken during a stuffed run");

	a_stuff_mark: assert property (@(posedge clk) disable iff (!arst_n)
		in_stuff_q |-> !s_axis_tready)
		else $error("stuffed run tracking lost");

endmodule

bind dle_stx_frame_encoder dse_chk u_dse_chk (.*);

[dv/tb_dle_stx_frame_encoder.sv]
// ----------------------------------------------------------------------------
// tb_dle_stx_frame_encoder
// Self-checking bench for the DLE/STX frame encoder. Words go in on the slave
// stream and framed bytes come out on the master stream. Each accepted input
// word is encoded by a behavioral copy of the framing rules (start marker,
// stuffed payload, trailer with XOR check). Each output byte is compared in
// order against that byte list. The bench runs directed corner cases, then
// random frames with noise words, random source gaps, sink stalls and one
// stretch with no idling at all.
// ----------------------------------------------------------------------------
module tb_dle_stx_frame_encoder;
	import dse_pkg::*;

	typedef struct {
		byte_t value;
		logic  last;
	} line_byte_t;

	logic       clk;
	logic       arst_n;
	logic       s_axis_tvalid;
	logic       s_axis_tready;
	logic [7:0] s_axis_tdata;   // [7:0] data_byte
	logic [1:0] s_axis_tuser;   // [0] has_data, [1] start_of_frame
	logic       s_axis_tlast;   // end_of_frame
	logic       m_axis_tvalid;
	logic       m_axis_tready;
	logic [7:0] m_axis_tdata;   // [7:0] out_byte
	logic       m_axis_tlast;   // run_last

	line_byte_t framed_q[$];
	byte_t      bcc_acc = '0;
	logic       in_frame = 1'b0;
	line_byte_t want;

	bit tx_gaps_on = 1'b1;
	bit rx_stalls_on = 1'b1;
	int rx_hold = 0;

	int fail_cnt = 0;
	int words_in = 0;
	int bytes_out = 0;
	int frames_closed = 0;
	int dle_stuffed = 0;
	int longest_run = 0;

	dle_stx_frame_encoder u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	initial clk = 1'b0;
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic int pick_len();
		if ($urandom_range(0, 9) == 0)
			return $urandom_range(8, 30);
		return $urandom_range(1, 3);
	endfunction

	function automatic byte_t pick_byte();
		case ($urandom_range(0, 7))
			0: return SYM_DLE;
			1: return SYM_STX;
			2: return SYM_ETX;
			default: return byte_t'($urandom_range(0, 255));
		endcase
	endfunction

	task automatic note_mismatch(input string msg);
		if (fail_cnt < 10)
			$display("%s", msg);
		fail_cnt++;
	endtask

	// Framing rules: start marker, stuffed payload, trailer with check.
	function automatic void encode_word(input byte_t data, input logic has,
			input logic sof, input logic eof);
		byte_t run[$];
		line_byte_t lb;
		if (sof) begin
			bcc_acc = '0;
			in_frame = 1'b1;
			run.push_back(SYM_DLE);
			run.push_back(SYM_STX);
		end
		if (has) begin
			if (data == SYM_DLE) begin
				run.push_back(SYM_DLE);
				dle_stuffed++;
			end
			run.push_back(data);
			bcc_acc = bcc_acc ^ data;
		end
		if (eof) begin
			run.push_back(SYM_DLE);
			run.push_back(SYM_ETX);
			run.push_back(bcc_acc ^ SYM_ETX);
			bcc_acc = '0;
			in_frame = 1'b0;
			frames_closed++;
		end
		if (run.size() > longest_run)
			longest_run = run.size();
		foreach (run[i]) begin
			lb.value = run[i];
			lb.last = (i == run.size() - 1);
			framed_q.push_back(lb);
		end
	endfunction

	always @(posedge clk) begin
		if (arst_n && s_axis_tvalid && s_axis_tready) begin
			encode_word(s_axis_tdata, s_axis_tuser[0], s_axis_tuser[1], s_axis_tlast);
			words_in++;
		end
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (framed_q.size() == 0) begin
				note_mismatch($sformatf("byte %0d: unexpected %02h last %0b",
					bytes_out, m_axis_tdata, m_axis_tlast));
			end else begin
				want = framed_q.pop_front();
				if (m_axis_tdata !== want.value || m_axis_tlast !== want.last)
					note_mismatch($sformatf(
						"byte %0d: expected %02h last %0b, got %02h last %0b",
						bytes_out, want.value, want.last, m_axis_tdata, m_axis_tlast));
			end
			bytes_out++;
		end
	end

	always @(posedge clk) begin
		if (rx_hold > 0) begin
			m_axis_tready <= 1'b0;
			rx_hold <= rx_hold - 1;
		end else if (rx_stalls_on && $urandom_range(0, 3) == 0) begin
			m_axis_tready <= 1'b0;
			rx_hold <= pick_len() - 1;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	task automatic send_word(input byte_t data, input logic has, input logic sof,
			input logic eof);
		int gap;
		gap = (tx_gaps_on && $urandom_range(0, 2) == 0) ? pick_len() : 0;
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= data;
		s_axis_tuser <= {sof, has};
		s_axis_tlast <= eof;
		do @(posedge clk); while (!s_axis_tready);
	endtask

	// Hold the source until every framed byte has come out.
	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (framed_q.size() != 0);
	endtask

	task automatic send_random_burst(output int n_words);
		int len;
		bit sof_alone;
		bit broken;
		logic [2:0] flags;
		n_words = 0;
		if ($urandom_range(0, 99) < 80) begin
			len = $urandom_range(0, 6);
			if (len == 0) begin
				send_word(byte_t'($urandom_range(0, 255)), 1'b0, 1'b1, 1'b1);
				n_words = 1;
			end else begin
				sof_alone = ($urandom_range(0, 5) == 0);
				broken = ($urandom_range(0, 9) == 0);
				if (sof_alone) begin
					send_word(byte_t'($urandom_range(0, 255)), 1'b0, 1'b1, 1'b0);
					n_words++;
				end
				for (int i = 0; i < len; i++) begin
					send_word(pick_byte(), 1'b1, (i == 0) && !sof_alone,
						(i == len - 1) && !broken);
					n_words++;
				end
			end
		end else begin
			flags = 3'($urandom_range(0, 7));
			send_word(byte_t'($urandom_range(0, 255)), flags[0], flags[1], flags[2]);
			if (flags != 3'b000)
				n_words = 1;
		end
	endtask

	task automatic test_stuffing_and_extremes();
		send_word(8'hA5, 1'b0, 1'b1, 1'b1);
		send_word(8'h5A, 1'b0, 1'b0, 1'b0);
		send_word(SYM_DLE, 1'b1, 1'b1, 1'b1);
		send_word(8'h00, 1'b1, 1'b1, 1'b0);
		send_word(8'hFF, 1'b1, 1'b0, 1'b0);
		send_word(SYM_STX, 1'b1, 1'b0, 1'b0);
		send_word(SYM_ETX, 1'b1, 1'b0, 1'b0);
		send_word(SYM_DLE, 1'b1, 1'b0, 1'b1);
		wait_drained();
	endtask

	task automatic test_frame_corner_cases();
		// restart an open frame
		send_word(8'h81, 1'b1, 1'b1, 1'b0);
		send_word(8'h7E, 1'b1, 1'b0, 1'b0);
		send_word(8'hC3, 1'b1, 1'b1, 1'b0);
		send_word(SYM_DLE, 1'b1, 1'b0, 1'b1);
		// payload and trailer with no frame open
		send_word(SYM_DLE, 1'b1, 1'b0, 1'b0);
		send_word(8'h3C, 1'b1, 1'b0, 1'b0);
		send_word(8'h00, 1'b0, 1'b0, 1'b1);
		send_word(8'hFF, 1'b0, 1'b0, 1'b1);
		// markers on words without payload
		send_word(8'hFF, 1'b0, 1'b1, 1'b0);
		send_word(8'hAA, 1'b1, 1'b0, 1'b0);
		send_word(8'h00, 1'b0, 1'b0, 1'b1);
		// idle word inside a frame
		send_word(8'h99, 1'b1, 1'b1, 1'b0);
		send_word(8'h12, 1'b0, 1'b0, 1'b0);
		send_word(8'h34, 1'b1, 1'b0, 1'b1);
		wait_drained();
	endtask

	task automatic test_back_to_back(input int n_words);
		int sent;
		int got;
		sent = 0;
		tx_gaps_on = 1'b0;
		rx_stalls_on = 1'b0;
		while (sent < n_words) begin
			send_random_burst(got);
			sent += got;
		end
		wait_drained();
		tx_gaps_on = 1'b1;
		rx_stalls_on = 1'b1;
	endtask

	task automatic test_random_frames(input int n_words);
		int sent;
		int got;
		int next_pause;
		sent = 0;
		next_pause = 25;
		while (sent < n_words) begin
			send_random_burst(got);
			sent += got;
			if (sent >= next_pause) begin
				wait_drained();
				next_pause += 25;
			end
		end
		wait_drained();
	endtask

	initial begin
		arst_n <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata <= '0;
		s_axis_tuser <= '0;
		s_axis_tlast <= 1'b0;
		m_axis_tready <= 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_stuffing_and_extremes();
		test_frame_corner_cases();
		test_back_to_back(20);
		test_random_frames(80);

		repeat (16) @(posedge clk);
		if (framed_q.size() != 0)
			note_mismatch($sformatf("%0d framed bytes never arrived", framed_q.size()));

		$display("covered %0d input words, %0d framed bytes, %0d frames closed",
			words_in, bytes_out, frames_closed);
		$display("stuffed %0d DLE payload bytes, longest run %0d bytes, %0d mismatches",
			dle_stuffed, longest_run, fail_cnt);
		if (fail_cnt == 0) begin
			$display("dle_stx_frame_encoder: match");
		end else begin
			$display("dle_stx_frame_encoder: mismatch");
		end
		$finish;
	end

	initial begin
		#4000000;
		$display("timeout");
		$display("dle_stx_frame_encoder: mismatch");
		$finish;
	end

endmodule
